FILE: src/ssl_pkg.sv
package ssl_pkg;

    // action codes carried by each input transaction
    typedef enum logic [1:0] {
        ACT_START    = 2'd0,
        ACT_SET_GOAL = 2'd1,
        ACT_TICK     = 2'd2,
        ACT_RAW      = 2'd3
    } ssl_action_t;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_REST_ANGLE      = 3'd0,
        REG_ANGLE_OFFSET    = 3'd1,
        REG_PWM_SLOPE       = 3'd2,
        REG_PWM_INTERCEPT   = 3'd3,
        REG_REACH_THRESHOLD = 3'd4,
        REG_WAIT_MS         = 3'd5
    } ssl_reg_idx_t;

    // configuration register contents
    typedef struct packed {
        logic signed [18:0] rest_angle;
        logic signed [16:0] angle_offset;
        logic signed [23:0] pwm_slope;
        logic signed [23:0] pwm_intercept;
        logic        [15:0] reach_threshold;
        logic        [7:0]  wait_ms;
    } ssl_cfg_t;

    // request to the shared multiplier
    typedef struct packed {
        logic               en;
        logic signed [27:0] a;
        logic signed [27:0] b;
    } ssl_mul_req_t;

    // goals at or below -998 degrees are ignored
    localparam logic signed [19:0] ANGLE_LIMIT = -20'sd255488;

    // divide by 1000 as multiply by ceil(2^36 / 1000) then shift by 36
    localparam logic [26:0] RECIP_1000  = 27'd68719477;
    localparam logic [25:0] ROUND_HALF  = 26'd500;

    localparam logic [8:0]  ELAPSED_MAX = 9'd256;
    localparam logic [11:0] PWM_MAX     = 12'd4095;

endpackage

FILE: src/servo_slew_limiter_pwm.sv
// Slew-rate limited servo driver. Each transaction carries one action (start, set goal,
// millisecond tick or raw pulse) and gives exactly one result. One signed multiplier is
// shared by a small sequencer for the step size (speed times wait, then divide by 1000
// through a reciprocal) and for the angle to pwm conversion, so the cost of a transaction
// follows how often that multiplier is used. Set goal, raw pulse and a tick that does not
// actuate go straight to the done state, start adds the pwm multiply, a tick that snaps to
// the goal adds the step check too, and a tick that moves one step the reciprocal and move.
// A result waiting in the output register while the output is stalled only holds the
// block when the following transaction is ready to be delivered.
module servo_slew_limiter_pwm
    import ssl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic signed [18:0] goal_angle,
    input  logic [17:0]        move_speed,
    input  logic               slow_mode,
    input  logic [11:0]        raw_pulse,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               pwm_write,
    output logic [11:0]        pwm_value,
    output logic signed [18:0] pose_estimate,
    output logic               goal_reached
);

    ssl_cfg_t cfg;

    // configuration registers
    ssl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer, servo state and shared multiplier
    ssl_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .goal_angle    (goal_angle),
        .move_speed    (move_speed),
        .slow_mode     (slow_mode),
        .raw_pulse     (raw_pulse),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pwm_write     (pwm_write),
        .pwm_value     (pwm_value),
        .pose_estimate (pose_estimate),
        .goal_reached  (goal_reached)
    );

endmodule

FILE: src/ssl_mul.sv
module ssl_mul
    import ssl_pkg::*;
(
    input  logic               clk,
    input  ssl_mul_req_t       req,
    output logic signed [55:0] p
);

    logic signed [55:0] p_reg;

    // shared signed multiplier with registered product
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            p_reg <= req.a * req.b;
        end
    end

    assign p = p_reg;

endmodule

FILE: src/ssl_cfg.sv
module ssl_cfg
    import ssl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output ssl_cfg_t    cfg
);

    ssl_cfg_t     cfg_reg;
    ssl_cfg_t     cfg_next;
    ssl_reg_idx_t reg_idx;
    logic         wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = ssl_reg_idx_t'(paddr[4:2]);

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_REST_ANGLE:      cfg_next.rest_angle      = pwdata[18:0];
                REG_ANGLE_OFFSET:    cfg_next.angle_offset    = pwdata[16:0];
                REG_PWM_SLOPE:       cfg_next.pwm_slope       = pwdata[23:0];
                REG_PWM_INTERCEPT:   cfg_next.pwm_intercept   = pwdata[23:0];
                REG_REACH_THRESHOLD: cfg_next.reach_threshold = pwdata[15:0];
                REG_WAIT_MS:         cfg_next.wait_ms         = pwdata[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rest_angle      <= '0;
            cfg_reg.angle_offset    <= '0;
            cfg_reg.pwm_slope       <= '0;
            cfg_reg.pwm_intercept   <= '0;
            cfg_reg.reach_threshold <= 16'd256;
            cfg_reg.wait_ms         <= 8'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // register read mux
    always_comb
    begin
        case (reg_idx)
            REG_REST_ANGLE:      prdata = {13'b0, cfg_reg.rest_angle};
            REG_ANGLE_OFFSET:    prdata = {15'b0, cfg_reg.angle_offset};
            REG_PWM_SLOPE:       prdata = {8'b0, cfg_reg.pwm_slope};
            REG_PWM_INTERCEPT:   prdata = {8'b0, cfg_reg.pwm_intercept};
            REG_REACH_THRESHOLD: prdata = {16'b0, cfg_reg.reach_threshold};
            REG_WAIT_MS:         prdata = {24'b0, cfg_reg.wait_ms};
            default:             prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/ssl_core.sv
module ssl_core
    import ssl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ssl_cfg_t           cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic signed [18:0] goal_angle,
    input  logic [17:0]        move_speed,
    input  logic               slow_mode,
    input  logic [11:0]        raw_pulse,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               pwm_write,
    output logic [11:0]        pwm_value,
    output logic signed [18:0] pose_estimate,
    output logic               goal_reached
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_STEP_MUL = 6'b000010,
        S_RECIP    = 6'b000100,
        S_MOVE     = 6'b001000,
        S_PWM_MUL  = 6'b010000,
        S_DONE     = 6'b100000
    } ssl_state_t;

    typedef enum logic [1:0] {
        PWM_NONE = 2'd0,
        PWM_CALC = 2'd1,
        PWM_RAW  = 2'd2
    } ssl_pwm_sel_t;

    ssl_state_t         state_reg, state_next;
    ssl_pwm_sel_t       pwm_sel_reg, pwm_sel_next;
    logic signed [19:0] current_pose_reg, current_pose_next;
    logic signed [19:0] goal_pose_reg, goal_pose_next;
    logic [17:0]        speed_reg, speed_next;
    logic               calibrating_reg, calibrating_next;
    logic               slow_mode_reg, slow_mode_next;
    logic [8:0]         elapsed_ms_reg, elapsed_ms_next;
    logic [11:0]        raw_reg, raw_next;
    logic               out_valid_reg, out_valid_next;
    logic               pwm_write_reg, pwm_write_next;
    logic [11:0]        pwm_value_reg, pwm_value_next;
    logic signed [18:0] pose_estimate_reg, pose_estimate_next;
    logic               goal_reached_reg, goal_reached_next;

    ssl_mul_req_t       mul_req;
    logic signed [55:0] mul_p;

    logic               accept;
    logic signed [20:0] offset_ext;
    logic signed [19:0] start_pose;
    logic signed [19:0] goal_ext;
    logic signed [19:0] new_goal;
    logic signed [20:0] pose_diff;
    logic [20:0]        pose_dist;
    logic               near;
    logic [8:0]         elapsed_inc;
    logic               tick_due;
    logic [16:0]        step;
    logic signed [20:0] step_signed;
    logic signed [20:0] moved;
    logic signed [19:0] moved_sat;
    logic signed [44:0] pwm_acc;
    logic [44:0]        pwm_round;
    logic [20:0]        pwm_count;
    logic [11:0]        pwm_calc;
    logic signed [20:0] est_wide;
    logic signed [18:0] est_sat;

    ssl_mul u_mul (
        .clk (clk),
        .req (mul_req),
        .p   (mul_p)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // pose arithmetic shared by several states
    assign offset_ext = {{4{cfg.angle_offset[16]}}, cfg.angle_offset};
    assign start_pose = {cfg.rest_angle[18], cfg.rest_angle} + offset_ext[19:0];
    assign goal_ext   = {goal_angle[18], goal_angle};
    assign new_goal   = goal_ext + offset_ext[19:0];

    assign pose_diff = {current_pose_reg[19], current_pose_reg}
                     - {goal_pose_reg[19], goal_pose_reg};
    assign pose_dist = pose_diff[20] ? 21'(-pose_diff) : 21'(pose_diff);
    assign near      = pose_dist < {5'b0, cfg.reach_threshold};

    // millisecond count, saturating
    assign elapsed_inc = (elapsed_ms_reg < ELAPSED_MAX) ? elapsed_ms_reg + 9'd1
                                                        : elapsed_ms_reg;
    assign tick_due = !calibrating_reg
                   && ((elapsed_inc > {1'b0, cfg.wait_ms}) || !slow_mode_reg)
                   && (goal_pose_reg > ANGLE_LIMIT);

    // one step toward the goal, upward when already there
    assign step        = mul_p[52:36];
    assign step_signed = (!pose_diff[20] && (pose_diff != 21'sd0))
                       ? -$signed({4'b0, step}) : $signed({4'b0, step});
    assign moved       = {current_pose_reg[19], current_pose_reg} + step_signed;
    assign moved_sat   = (moved[20] != moved[19])
                       ? (moved[20] ? 20'sh80000 : 20'sh7FFFF) : moved[19:0];

    // pwm count from product: round half up, saturate to 0..4095
    assign pwm_acc   = $signed(mul_p[44:0])
                     + $signed({{5{cfg.pwm_intercept[23]}}, cfg.pwm_intercept, 16'b0});
    assign pwm_round = pwm_acc + 45'd8388608;
    assign pwm_count = pwm_round[44:24];
    assign pwm_calc  = pwm_acc[44] ? 12'd0
                     : ((pwm_count > {9'b0, PWM_MAX}) ? PWM_MAX : pwm_count[11:0]);

    // pose estimate without offset, saturated to 19 bits
    assign est_wide = {current_pose_reg[19], current_pose_reg} - offset_ext;
    assign est_sat  = ((est_wide[20:18] == 3'b000) || (est_wide[20:18] == 3'b111))
                    ? est_wide[18:0]
                    : (est_wide[20] ? 19'sh40000 : 19'sh3FFFF);

    // sequencer and state update
    always_comb
    begin
        state_next         = state_reg;
        pwm_sel_next       = pwm_sel_reg;
        current_pose_next  = current_pose_reg;
        goal_pose_next     = goal_pose_reg;
        speed_next         = speed_reg;
        calibrating_next   = calibrating_reg;
        slow_mode_next     = slow_mode_reg;
        elapsed_ms_next    = elapsed_ms_reg;
        raw_next           = raw_reg;
        out_valid_next     = out_valid_reg && out_stall;
        pwm_write_next     = pwm_write_reg;
        pwm_value_next     = pwm_value_reg;
        pose_estimate_next = pose_estimate_reg;
        goal_reached_next  = goal_reached_reg;
        mul_req.en         = 1'b0;
        mul_req.a          = '0;
        mul_req.b          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (ssl_action_t'(action))
                        ACT_START:
                        begin
                            goal_pose_next    = start_pose;
                            current_pose_next = start_pose;
                            elapsed_ms_next   = '0;
                            pwm_sel_next      = PWM_CALC;
                            state_next        = S_PWM_MUL;
                        end
                        ACT_SET_GOAL:
                        begin
                            calibrating_next = 1'b0;
                            slow_mode_next   = slow_mode;
                            if (goal_ext > ANGLE_LIMIT)
                            begin
                                goal_pose_next = new_goal;
                                speed_next     = move_speed;
                            end
                            pwm_sel_next = PWM_NONE;
                            state_next   = S_DONE;
                        end
                        ACT_TICK:
                        begin
                            if (tick_due)
                            begin
                                elapsed_ms_next = '0;
                                pwm_sel_next    = PWM_CALC;
                                state_next      = S_STEP_MUL;
                            end
                            else
                            begin
                                elapsed_ms_next = elapsed_inc;
                                pwm_sel_next    = PWM_NONE;
                                state_next      = S_DONE;
                            end
                        end
                        ACT_RAW:
                        begin
                            calibrating_next = 1'b1;
                            raw_next         = raw_pulse;
                            pwm_sel_next     = PWM_RAW;
                            state_next       = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_STEP_MUL:
            begin
                if (near)
                begin
                    current_pose_next = goal_pose_reg;
                    state_next        = S_PWM_MUL;
                end
                else
                begin
                    mul_req.en = 1'b1;
                    mul_req.a  = $signed({10'b0, speed_reg});
                    mul_req.b  = $signed({20'b0, cfg.wait_ms});
                    state_next = S_RECIP;
                end
            end
            S_RECIP:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = $signed({2'b0, mul_p[25:0] + ROUND_HALF});
                mul_req.b  = $signed({1'b0, RECIP_1000});
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                current_pose_next = moved_sat;
                state_next        = S_PWM_MUL;
            end
            S_PWM_MUL:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = $signed({{8{current_pose_reg[19]}}, current_pose_reg});
                mul_req.b  = $signed({{4{cfg.pwm_slope[23]}}, cfg.pwm_slope});
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next     = 1'b1;
                    pwm_write_next     = (pwm_sel_reg != PWM_NONE);
                    case (pwm_sel_reg)
                        PWM_CALC: pwm_value_next = pwm_calc;
                        PWM_RAW:  pwm_value_next = raw_reg;
                        default:  pwm_value_next = '0;
                    endcase
                    pose_estimate_next = est_sat;
                    goal_reached_next  = near;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            current_pose_reg <= '0;
            goal_pose_reg    <= '0;
            speed_reg        <= '0;
            calibrating_reg  <= 1'b0;
            slow_mode_reg    <= 1'b0;
            elapsed_ms_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            current_pose_reg <= current_pose_next;
            goal_pose_reg    <= goal_pose_next;
            speed_reg        <= speed_next;
            calibrating_reg  <= calibrating_next;
            slow_mode_reg    <= slow_mode_next;
            elapsed_ms_reg   <= elapsed_ms_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pwm_sel_reg       <= pwm_sel_next;
        raw_reg           <= raw_next;
        pwm_write_reg     <= pwm_write_next;
        pwm_value_reg     <= pwm_value_next;
        pose_estimate_reg <= pose_estimate_next;
        goal_reached_reg  <= goal_reached_next;
    end

    assign out_valid     = out_valid_reg;
    assign pwm_write     = pwm_write_reg;
    assign pwm_value     = pwm_value_reg;
    assign pose_estimate = pose_estimate_reg;
    assign goal_reached  = goal_reached_reg;

    // a new result is only ever loaded from the final state
    a_result_from_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE)
    ) else $error("result issued outside final state");

    // an accepted transaction makes the block busy
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> in_stall
    ) else $error("block not busy after accepting a transaction");

    // pose holds while idle with nothing accepted
    a_pose_holds_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && !accept |=> $stable(current_pose_reg)
    ) else $error("pose changed while idle");

    // no pulse count without a write
    a_no_pwm_without_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pwm_write_reg |-> (pwm_value_reg == 12'd0)
    ) else $error("pwm value given without a write");

endmodule
